/* hdl/gcd_lcm_unit_macros.svh */
// Assertion macros used by the checker file of the gcd/lcm unit.
// Each macro expands to one labeled concurrent assertion on the rising clock
// edge, disabled while reset is high.
`ifndef GCD_LCM_UNIT_MACROS_SVH
`define GCD_LCM_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GLU_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GLU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/glu_pkg.sv */
`timescale 1ns / 1ps

package glu_pkg;

   localparam int OPERAND_BITS = 16;
   localparam int LCM_BITS     = 2 * OPERAND_BITS;
   localparam int CNT_BITS     = $clog2(OPERAND_BITS);

   // Count value of the last quotient bit in the division pass.
   localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(OPERAND_BITS - 1);

   typedef struct packed {
      logic [OPERAND_BITS-1:0] operand_a;
      logic [OPERAND_BITS-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [OPERAND_BITS-1:0] gcd_value;
      logic [LCM_BITS-1:0]     lcm_value;
      logic                    zero_operand_error;
   } rsp_type;

endpackage

/* hdl/gcd_lcm_unit.sv */
`timescale 1ns / 1ps

// gcd_lcm_unit: greatest common divisor and least common multiple of two
// unsigned operands.
//
// Request channel (req_valid, req_stall, req_payload) carries one operand
// pair per beat. Response channel (rsp_valid, rsp_stall, rsp_payload) returns
// one beat per request: the gcd, the lcm and a flag that is set when either
// operand is zero (gcd and lcm then read zero).
// One request is worked on at a time; req_stall stays high from the beat
// after acceptance until the result has been moved into the output register.
// A zero operand goes from the align step straight to the output step.
// Otherwise the block removes common factors of two, runs a binary gcd loop
// of shifts, subtractions and swaps, divides the first operand by the gcd
// one quotient bit per cycle and multiplies the quotient by the second
// operand on the way into the output register. Every subtraction goes
// through one shared subtractor.
// The output register frees the request side: a new request is taken while
// a result waits under rsp_stall, and that request's result holds in the
// last step until the register is free. Reset empties the output register
// and returns the sequencer to idle; no other state is kept between items.

module gcd_lcm_unit
   import glu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_REDUCE,
      ST_DIVIDE,
      ST_OUTPUT
   } state_type;

   state_type               state_ff, state_in;
   logic [OPERAND_BITS-1:0] x_ff, x_in;
   logic [OPERAND_BITS-1:0] y_ff, y_in;
   logic [OPERAND_BITS-1:0] a_ff, a_in;
   logic [OPERAND_BITS-1:0] b_ff, b_in;
   logic [OPERAND_BITS-1:0] gcd_ff, gcd_in;
   logic [CNT_BITS-1:0]     k_ff, k_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic                    err_ff, err_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Shared subtractor with borrow out.
   logic [OPERAND_BITS:0]   sub_l, sub_r;
   logic [OPERAND_BITS+1:0] sub_res;
   logic                    sub_borrow;
   logic [OPERAND_BITS:0]   sub_diff;

   logic                    req_take;
   logic                    out_free;
   logic [OPERAND_BITS:0]   trial;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Partial remainder with the next dividend bit brought down.
   assign trial = {y_ff, x_ff[OPERAND_BITS-1]};

   always_comb begin
      sub_l = '0;
      sub_r = '0;
      case (state_ff)
         ST_REDUCE: begin
            sub_l = {1'b0, x_ff};
            sub_r = {1'b0, y_ff};
         end
         ST_DIVIDE: begin
            sub_l = trial;
            sub_r = {1'b0, gcd_ff};
         end
         default: begin
            sub_l = '0;
            sub_r = '0;
         end
      endcase
   end

   assign sub_res    = {1'b0, sub_l} - {1'b0, sub_r};
   assign sub_borrow = sub_res[OPERAND_BITS+1];
   assign sub_diff   = sub_res[OPERAND_BITS:0];

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      gcd_in       = gcd_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      err_in       = err_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               x_in     = req_payload.operand_a;
               y_in     = req_payload.operand_b;
               a_in     = req_payload.operand_a;
               b_in     = req_payload.operand_b;
               k_in     = '0;
               err_in   = (req_payload.operand_a == '0) || (req_payload.operand_b == '0);
               state_in = ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            // Strip the factors of two that both operands share; k counts them.
            if (err_ff) begin
               state_in = ST_OUTPUT;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + 1'b1;
            end else begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (!sub_borrow && (sub_diff == '0)) begin
               gcd_in   = x_ff << k_ff;
               x_in     = a_ff;
               y_in     = '0;
               cnt_in   = '0;
               state_in = ST_DIVIDE;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (!sub_borrow) begin
               x_in = sub_diff[OPERAND_BITS-1:0];
            end else begin
               // Keep the larger value in x so the subtractor runs one way.
               x_in = y_ff;
               y_in = x_ff;
            end
         end
         ST_DIVIDE: begin
            // Restoring division: x shifts the dividend out and the quotient in,
            // y holds the partial remainder.
            if (!sub_borrow) begin
               y_in = sub_diff[OPERAND_BITS-1:0];
               x_in = {x_ff[OPERAND_BITS-2:0], 1'b1};
            end else begin
               y_in = trial[OPERAND_BITS-1:0];
               x_in = {x_ff[OPERAND_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (out_free) begin
               if (err_ff) begin
                  rsp_in.gcd_value = '0;
                  rsp_in.lcm_value = '0;
               end else begin
                  rsp_in.gcd_value = gcd_ff;
                  rsp_in.lcm_value = LCM_BITS'(x_ff) * LCM_BITS'(b_ff);
               end
               rsp_in.zero_operand_error = err_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      gcd_ff <= gcd_in;
      k_ff   <= k_in;
      cnt_ff <= cnt_in;
      err_ff <= err_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hdl/gcd_lcm_unit_checker.sv */
`timescale 1ns / 1ps
`include "gcd_lcm_unit_macros.svh"

module gcd_lcm_unit_checker
   import glu_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   logic req_beat;

   assign req_beat = req_valid && !req_stall;

   // A stalled response beat keeps its valid and its payload.
   `GLU_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "response changed while stalled")

   // Only one request is in work at a time.
   `GLU_ASSERT_NEXT(a_busy_after_take, req_beat, req_stall, "request side ready right after a beat")

   // An error result carries zero gcd and lcm.
   `GLU_ASSERT_SAME(a_err_zero, rsp_valid && rsp_payload.zero_operand_error, (rsp_payload.gcd_value == '0) && (rsp_payload.lcm_value == '0), "error result with nonzero values")

   // A valid result has a nonzero gcd that does not exceed the lcm.
   `GLU_ASSERT_SAME(a_ok_range, rsp_valid && !rsp_payload.zero_operand_error, (rsp_payload.gcd_value != '0) && (LCM_BITS'(rsp_payload.gcd_value) <= rsp_payload.lcm_value), "gcd zero or above lcm")

endmodule

bind gcd_lcm_unit gcd_lcm_unit_checker u_checker (.*);
